### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. All checks are clocked on clock and
// are off while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fmbq_pkg.sv
// ---------------------------------------------------------------------------
// fmbq_pkg
// Types, codes and sizes for the front/middle/back queue.
// ---------------------------------------------------------------------------
package fmbq_pkg;

   // Storage geometry
   localparam int CAPACITY = 64;
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int CNT_W    = POS_W + 1;
   localparam int GROUP    = 8;
   localparam int GRP_W    = $clog2(GROUP);
   localparam int NGROUP   = CAPACITY / GROUP;
   localparam int SEL_W    = POS_W - GRP_W;

   typedef logic signed [31:0] word_type;

   localparam word_type WORD_NEG_ONE = -32'sd1;
   localparam word_type WORD_ZERO    = 32'sd0;

   // Operation codes
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_MID   = 3'd1;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_POP_MID    = 3'd4;
   localparam logic [2:0] KIND_POP_BACK   = 3'd5;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      word_type   value;
   } req_type;

   typedef struct packed {
      word_type   popped_value;
      logic [1:0] status;
      logic [6:0] occupancy;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic gather;
      logic pick;
      logic apply;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

### rtl/fmbq_ctrl.sv
// ---------------------------------------------------------------------------
// fmbq_ctrl
// Sequencer: accept, gather the addressed word through the select tree,
// then apply the shift and post the response.
// ---------------------------------------------------------------------------
module fmbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmbq_pkg::stat_type stat,
   output fmbq_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_GATHER = 2'd1;
   localparam logic [1:0] ST_PICK   = 2'd2;
   localparam logic [1:0] ST_APPLY  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            cmd.gather = 1'b1;
            state_in   = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // wait until the response register can take the result
            if (stat.out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/fmbq_dpath.sv
// ---------------------------------------------------------------------------
// fmbq_dpath
// Row of shifting cells, two-level registered select tree for reads,
// occupancy count and the response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fmbq_dpath (
   input  logic               clock,
   input  logic               reset,
   input  fmbq_pkg::req_type  req_data,
   input  fmbq_pkg::cmd_type  cmd,
   output fmbq_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fmbq_pkg::rsp_type  rsp_data
);

   // Latched transaction
   logic [2:0]                  kind_ff;
   fmbq_pkg::word_type          value_ff;
   logic [fmbq_pkg::POS_W-1:0]  pos_ff;
   logic [fmbq_pkg::POS_W-1:0]  pos_in;
   logic [fmbq_pkg::CNT_W-1:0]  count_ff;
   logic [fmbq_pkg::CNT_W-1:0]  count_in;
   logic [fmbq_pkg::CNT_W-1:0]  count_dec;

   // Storage and select tree
   fmbq_pkg::word_type cells_ff [fmbq_pkg::CAPACITY];
   fmbq_pkg::word_type cells_in [fmbq_pkg::CAPACITY];
   fmbq_pkg::word_type grp_ff   [fmbq_pkg::NGROUP];
   fmbq_pkg::word_type word_ff;

   // Response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   fmbq_pkg::rsp_type rsp_ff;
   fmbq_pkg::rsp_type rsp_in;

   logic is_push;
   logic is_pop;
   logic full;
   logic empty;
   logic do_insert;
   logic do_remove;

   // Target position from the current occupancy
   assign count_dec = fmbq_pkg::CNT_W'(count_ff - 1'b1);

   always_comb begin
      pos_in = '0;
      unique case (req_data.kind)
         fmbq_pkg::KIND_PUSH_FRONT: pos_in = '0;
         fmbq_pkg::KIND_PUSH_MID:   pos_in = count_ff[fmbq_pkg::CNT_W-1:1];
         fmbq_pkg::KIND_PUSH_BACK:  pos_in = count_ff[fmbq_pkg::POS_W-1:0];
         fmbq_pkg::KIND_POP_FRONT:  pos_in = '0;
         fmbq_pkg::KIND_POP_MID:    pos_in = count_dec[fmbq_pkg::CNT_W-1:1];
         fmbq_pkg::KIND_POP_BACK:   pos_in = count_dec[fmbq_pkg::POS_W-1:0];
         default:                   pos_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_data.kind;
         value_ff <= req_data.value;
         pos_ff   <= pos_in;
      end
   end

   // Operation decode
   assign is_push = (kind_ff == fmbq_pkg::KIND_PUSH_FRONT) ||
                    (kind_ff == fmbq_pkg::KIND_PUSH_MID) ||
                    (kind_ff == fmbq_pkg::KIND_PUSH_BACK);
   assign is_pop  = (kind_ff == fmbq_pkg::KIND_POP_FRONT) ||
                    (kind_ff == fmbq_pkg::KIND_POP_MID) ||
                    (kind_ff == fmbq_pkg::KIND_POP_BACK);
   assign full      = (count_ff == fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY));
   assign empty     = (count_ff == '0);
   assign do_insert = cmd.apply && is_push && !full;
   assign do_remove = cmd.apply && is_pop && !empty;

   // Cell row: each cell holds, loads the new word, or takes a neighbor
   for (genvar g = 0; g < fmbq_pkg::CAPACITY; g++) begin : g_cell
      fmbq_pkg::word_type prev_word;
      fmbq_pkg::word_type next_word;

      if (g == 0) begin : g_first
         assign prev_word = value_ff;
      end else begin : g_mid
         assign prev_word = cells_ff[g-1];
      end

      if (g == fmbq_pkg::CAPACITY - 1) begin : g_last
         assign next_word = cells_ff[g];
      end else begin : g_body
         assign next_word = cells_ff[g+1];
      end

      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_insert) begin
            if (fmbq_pkg::POS_W'(g) == pos_ff) begin
               cells_in[g] = value_ff;
            end else if (fmbq_pkg::POS_W'(g) > pos_ff) begin
               cells_in[g] = prev_word;
            end
         end else if (do_remove && (fmbq_pkg::POS_W'(g) >= pos_ff)) begin
            cells_in[g] = next_word;
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[g] <= cells_in[g];
      end
   end

   // Select tree, first level: one word out of each group
   for (genvar g = 0; g < fmbq_pkg::NGROUP; g++) begin : g_grp
      always_ff @(posedge clock) begin
         if (cmd.gather) begin
            grp_ff[g] <= cells_ff[{fmbq_pkg::SEL_W'(g), pos_ff[fmbq_pkg::GRP_W-1:0]}];
         end
      end
   end

   // Select tree, second level
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         word_ff <= grp_ff[pos_ff[fmbq_pkg::POS_W-1:fmbq_pkg::GRP_W]];
      end
   end

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = fmbq_pkg::CNT_W'(count_ff + 1'b1);
      end else if (do_remove) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response build
   always_comb begin
      rsp_in.popped_value = fmbq_pkg::WORD_ZERO;
      rsp_in.status       = fmbq_pkg::STAT_OK;
      rsp_in.occupancy    = 7'(count_in);
      if (is_push && full) begin
         rsp_in.status = fmbq_pkg::STAT_FULL;
      end else if (is_pop && empty) begin
         rsp_in.popped_value = fmbq_pkg::WORD_NEG_ONE;
         rsp_in.status       = fmbq_pkg::STAT_EMPTY;
      end else if (is_pop) begin
         rsp_in.popped_value = word_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in  = cmd.apply || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY),
      "occupancy above capacity")
   `ASSERT_IMPL(a_no_overwrite, cmd.apply, stat.out_free,
      "result posted over a pending response")
   `ASSERT_NEXT(a_push_grows, do_insert,
      count_ff == fmbq_pkg::CNT_W'($past(count_ff) + 1'b1),
      "accepted push did not grow occupancy")

endmodule

### rtl/front_middle_back_queue_top.sv
// After a request is accepted the sequencer steps through gather, pick
// and apply; the response is registered on apply. No new request is taken
// until then, as the two-level registered select tree reads the addressed
// cell before the row shifts. A stalled response holds the sequencer in
// its final step until taken. Reset (synchronous, active high) empties
// the queue; stored words are not cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
// front_middle_back_queue_top
// Ordered queue with push and pop at front, middle and back.
// ---------------------------------------------------------------------------
module front_middle_back_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fmbq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fmbq_pkg::rsp_type rsp_data
);

   fmbq_pkg::cmd_type  cmd;
   fmbq_pkg::stat_type stat;

   // Sequencer
   fmbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and response
   fmbq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
